// ===== design/assert_macros.svh =====
// Assertion helpers. Compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("assertion violated");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("assertion violated");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif

`endif

// ===== design/pcmf_pkg.sv =====
`default_nettype none

package pcmf_pkg;

    localparam int CH_FIELD_W  = 5;
    localparam int VAL_FIELD_W = 12;

    localparam int DEF_SAMPLES    = 64;
    localparam int DEF_CHANNELS   = 32;
    localparam int DEF_VALUE_BITS = 12;

    typedef struct packed {
        logic [CH_FIELD_W-1:0]  channel;
        logic [VAL_FIELD_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic [CH_FIELD_W-1:0]  out_channel;
        logic [VAL_FIELD_W-1:0] median;
        logic                   last_result;
    } t_out_word;

endpackage

`default_nettype wire

// ===== design/per_channel_median_filter_top.sv =====
`default_nettype none
// Per-channel median filter.
//
// Input channel (i_in_valid / o_in_ready / i_in): one word per converter
// sample, a channel number and a value. Channel numbers at or above CHANNELS
// are saturated to CHANNELS-1; value bits above VALUE_BITS are dropped.
// Words are written into a SAMPLES-deep frame store, one per cycle while loading.
//
// Output channel (o_out_valid / i_out_ready / o_out): once the frame is full
// the block reports one word per distinct channel, in order of first
// appearance, carrying the channel and the element at index count/2 of its
// ascending-sorted values. The final word of the frame has last_result set.
//
// After the last word the input is held off while one rank counter on the store's
// single read port works: a scan of the entries for first appearances, then per
// channel a count pass and hand-off, a rank pass per candidate tried and a
// re-read of each entry skipped.
// Reset clears the sequencer, fill count and output valid, not the store.
// A stalled receiver holds one word in the output register and one pending;
// the search then waits.
`include "assert_macros.svh"

module per_channel_median_filter_top #(
    parameter int SAMPLES    = pcmf_pkg::DEF_SAMPLES,
    parameter int CHANNELS   = pcmf_pkg::DEF_CHANNELS,
    parameter int VALUE_BITS = pcmf_pkg::DEF_VALUE_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  pcmf_pkg::t_in_word  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output pcmf_pkg::t_out_word o_out
);
    import pcmf_pkg::*;

    localparam int IDX_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam int CNT_W = $clog2(SAMPLES + 1);
    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int VW    = (VALUE_BITS < VAL_FIELD_W) ? VALUE_BITS : VAL_FIELD_W;
    localparam int MW    = CH_W + VW;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLES - 1);

    typedef enum logic [3:0] {
        S_LOAD,      // taking samples
        S_OUT_RD,    // read entry p
        S_OUT_CHK,   // new channel at p?
        S_CNT,       // count this channel's samples
        S_CAND_RD,   // read candidate j
        S_CAND_CHK,  // candidate belongs to channel?
        S_RANK,      // count smaller / equal values
        S_EMIT,      // hand median to pending slot
        S_FLUSH      // push final word with last mark
    } t_state;

    // frame store
    logic [MW-1:0]    r_mem [SAMPLES];
    logic [MW-1:0]    r_rd_word;
    logic [IDX_W-1:0] rd_addr;
    logic [CH_W-1:0]  rd_ch;
    logic [VW-1:0]    rd_val;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_fill, n_fill;
    logic [IDX_W-1:0] r_p, n_p;
    logic [IDX_W-1:0] r_j, n_j;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_issue, n_issue;
    logic             r_dvld, n_dvld;
    logic             r_dlast, n_dlast;
    logic [CHANNELS-1:0] r_mask, n_mask;
    logic [CH_W-1:0]  r_cur_ch, n_cur_ch;
    logic [CNT_W-1:0] r_n, n_n;
    logic [CNT_W-1:0] r_k, n_k;
    logic [CNT_W-1:0] r_less, n_less;
    logic [CNT_W-1:0] r_eq, n_eq;
    logic [VW-1:0]    r_cand, n_cand;
    logic             r_pend_vld, n_pend_vld;
    logic [CH_W-1:0]  r_pend_ch, n_pend_ch;
    logic [VW-1:0]    r_pend_med, n_pend_med;
    logic             r_out_vld, n_out_vld;
    t_out_word        r_out, n_out;

    logic             in_fire;
    logic             out_free;
    logic             push;
    logic [CH_W-1:0]  in_ch;
    logic [VW-1:0]    in_val;
    logic [CNT_W:0]   rank_hi;

    assign o_in_ready  = (r_state == S_LOAD);
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;
    assign out_free    = !r_out_vld || i_out_ready;

    assign in_ch  = ({1'b0, i_in.channel} >= (CH_FIELD_W + 1)'(CHANNELS))
                    ? CH_W'(CHANNELS - 1) : CH_W'(i_in.channel);
    assign in_val = i_in.value[VW-1:0];

    assign rd_ch  = r_rd_word[MW-1:VW];
    assign rd_val = r_rd_word[VW-1:0];

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_mem[r_fill] <= {in_ch, in_val};
        end
        r_rd_word <= r_mem[rd_addr];
    end

    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_p        = r_p;
        n_j        = r_j;
        n_idx      = r_idx;
        n_issue    = r_issue;
        n_dvld     = 1'b0;
        n_dlast    = 1'b0;
        n_mask     = r_mask;
        n_cur_ch   = r_cur_ch;
        n_n        = r_n;
        n_k        = r_k;
        n_less     = r_less;
        n_eq       = r_eq;
        n_cand     = r_cand;
        n_pend_vld = r_pend_vld;
        n_pend_ch  = r_pend_ch;
        n_pend_med = r_pend_med;
        n_out_vld  = r_out_vld && !i_out_ready;
        n_out      = r_out;
        push       = 1'b0;
        rd_addr    = r_idx;
        rank_hi    = '0;

        // streaming scan: one address issued per cycle, data returned in the cycle after
        if ((r_state == S_CNT || r_state == S_RANK) && r_issue) begin
            n_dvld  = 1'b1;
            n_dlast = (r_idx == LAST_IDX);
            if (r_idx == LAST_IDX) begin
                n_issue = 1'b0;
            end else begin
                n_idx = r_idx + 1'b1;
            end
        end

        case (r_state)
            S_LOAD: begin
                if (in_fire) begin
                    if (r_fill == LAST_IDX) begin
                        n_fill     = '0;
                        n_p        = '0;
                        n_mask     = '0;
                        n_pend_vld = 1'b0;
                        n_state    = S_OUT_RD;
                    end else begin
                        n_fill = r_fill + 1'b1;
                    end
                end
            end
            S_OUT_RD: begin
                rd_addr = r_p;
                n_state = S_OUT_CHK;
            end
            S_OUT_CHK: begin
                if (r_mask[rd_ch]) begin
                    if (r_p == LAST_IDX) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_p     = r_p + 1'b1;
                        n_state = S_OUT_RD;
                    end
                end else begin
                    n_mask[rd_ch] = 1'b1;
                    n_cur_ch      = rd_ch;
                    n_n           = '0;
                    n_idx         = '0;
                    n_issue       = 1'b1;
                    n_state       = S_CNT;
                end
            end
            S_CNT: begin
                if (r_dvld && rd_ch == r_cur_ch) begin
                    n_n = r_n + 1'b1;
                end
                if (r_dvld && r_dlast) begin
                    n_k     = n_n >> 1;
                    n_j     = r_p;   // first sample of the channel
                    n_state = S_CAND_RD;
                end
            end
            S_CAND_RD: begin
                rd_addr = r_j;
                n_state = S_CAND_CHK;
            end
            S_CAND_CHK: begin
                if (rd_ch == r_cur_ch) begin
                    n_cand  = rd_val;
                    n_less  = '0;
                    n_eq    = '0;
                    n_idx   = '0;
                    n_issue = 1'b1;
                    n_state = S_RANK;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = S_CAND_RD;
                end
            end
            S_RANK: begin
                if (r_dvld && rd_ch == r_cur_ch) begin
                    if (rd_val < r_cand) begin
                        n_less = r_less + 1'b1;
                    end
                    if (rd_val == r_cand) begin
                        n_eq = r_eq + 1'b1;
                    end
                end
                rank_hi = (CNT_W + 1)'(n_less) + (CNT_W + 1)'(n_eq);
                if (r_dvld && r_dlast) begin
                    // candidate sits at index k when less <= k < less + eq
                    if (n_less <= r_k && (CNT_W + 1)'(r_k) < rank_hi) begin
                        n_state = S_EMIT;
                    end else begin
                        n_j     = r_j + 1'b1;
                        n_state = S_CAND_RD;
                    end
                end
            end
            S_EMIT: begin
                if (!r_pend_vld || out_free) begin
                    if (r_pend_vld) begin
                        push = 1'b1;
                        n_out_vld         = 1'b1;
                        n_out.out_channel = CH_FIELD_W'(r_pend_ch);
                        n_out.median      = VAL_FIELD_W'(r_pend_med);
                        n_out.last_result = 1'b0;
                    end
                    n_pend_vld = 1'b1;
                    n_pend_ch  = r_cur_ch;
                    n_pend_med = r_cand;
                    if (r_p == LAST_IDX) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_p     = r_p + 1'b1;
                        n_state = S_OUT_RD;
                    end
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    push = 1'b1;
                    n_out_vld         = 1'b1;
                    n_out.out_channel = CH_FIELD_W'(r_pend_ch);
                    n_out.median      = VAL_FIELD_W'(r_pend_med);
                    n_out.last_result = 1'b1;
                    n_pend_vld        = 1'b0;
                    n_state           = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_p        <= n_p;
        r_j        <= n_j;
        r_idx      <= n_idx;
        r_cur_ch   <= n_cur_ch;
        r_n        <= n_n;
        r_k        <= n_k;
        r_less     <= n_less;
        r_eq       <= n_eq;
        r_cand     <= n_cand;
        r_pend_ch  <= n_pend_ch;
        r_pend_med <= n_pend_med;
        r_out      <= n_out;
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_fill     <= '0;
            r_issue    <= 1'b0;
            r_dvld     <= 1'b0;
            r_dlast    <= 1'b0;
            r_mask     <= '0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_fill     <= n_fill;
            r_issue    <= n_issue;
            r_dvld     <= n_dvld;
            r_dlast    <= n_dlast;
            r_mask     <= n_mask;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    // never overwrite a word the receiver has not taken
    `ASSERT_IMPLIES(a_push_free, i_clk, i_rst_n, push, (!r_out_vld || i_out_ready))
    // a frame always holds a pending result to carry the last mark
    `ASSERT_IMPLIES(a_flush_pend, i_clk, i_rst_n, (r_state == S_FLUSH), r_pend_vld)
    // candidates never precede the channel's first sample
    `ASSERT_IMPLIES(a_cand_order, i_clk, i_rst_n, (r_state == S_CAND_RD), (r_j >= r_p))
    // target rank lies inside the channel's sample count
    `ASSERT_IMPLIES(a_rank_range, i_clk, i_rst_n, (r_state == S_RANK), (r_k < r_n))
    // fill count only moves while loading
    `ASSERT_NEXT(a_fill_hold, i_clk, i_rst_n, (r_state != S_LOAD), $stable(r_fill))

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import pcmf_pkg::*;

    localparam int SAMPLES       = DEF_SAMPLES;
    localparam int CHANNELS      = DEF_CHANNELS;
    localparam int VALUE_BITS    = DEF_VALUE_BITS;
    localparam int RANDOM_FRAMES = 2;
    localparam int CYCLE_LIMIT   = 1_000_000;
    // wait after the last expected median; nothing may come out in this time
    localparam int DRAIN_CYCLES  = 2 * SAMPLES * (SAMPLES + 3);
    localparam logic [VAL_FIELD_W-1:0] VAL_MASK = VAL_FIELD_W'((1 << VALUE_BITS) - 1);

    // one row of the directed plan: a run of words, channel and value stepping per word
    typedef struct {
        logic [CH_FIELD_W-1:0]  ch;
        logic [VAL_FIELD_W-1:0] val;
        int                     reps;
        int                     ch_step;
        int                     val_step;
        bit                     pinned;     // frame result typed in below
        t_out_word              exp_word;
    } t_stim_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_word  i_in;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_word o_out;

    // predictor copy of the frame store
    logic [CH_FIELD_W-1:0]  frame_ch  [SAMPLES];
    logic [VAL_FIELD_W-1:0] frame_val [SAMPLES];
    int                     frame_fill = 0;

    t_out_word median_q [$];    // medians still owed by the block, oldest first
    t_out_word typed_q  [$];    // hand-written frame results for pinned rows
    t_out_word want;
    t_stim_row plan [7];
    int        mismatches  = 0;
    int        cycle_count = 0;
    bit        quiet_in    = 1'b0;

    per_channel_median_filter_top #(
        .SAMPLES    (SAMPLES),
        .CHANNELS   (CHANNELS),
        .VALUE_BITS (VALUE_BITS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, exp_val);
        mismatches++;
    endtask

    // element at index count/2 of the channel's ascending values
    function automatic logic [VAL_FIELD_W-1:0] rank_middle(input logic [CH_FIELD_W-1:0] c);
        logic [VAL_FIELD_W-1:0] vals [$];
        logic [VAL_FIELD_W-1:0] t;
        int n;
        int k;
        for (int i = 0; i < SAMPLES; i++)
            if (frame_ch[i] == c) vals.push_back(frame_val[i]);
        n = vals.size();
        for (int i = 1; i < n; i++) begin
            t = vals[i];
            k = i;
            while (k > 0 && vals[k-1] > t) begin
                vals[k] = vals[k-1];
                k--;
            end
            vals[k] = t;
        end
        return vals[n / 2];
    endfunction

    // store one accepted word; a full frame queues one median per channel, or the typed result of a pinned row
    task automatic absorb_sample(input t_in_word w);
        logic [31:0] done_mask;
        t_out_word   held;
        bit          have_held;
        int          c;
        c = int'(w.channel);
        if (c >= CHANNELS) c = CHANNELS - 1;
        if (frame_fill >= SAMPLES) frame_fill = 0;
        frame_ch[frame_fill]  = CH_FIELD_W'(c);
        frame_val[frame_fill] = w.value & VAL_MASK;
        frame_fill++;
        if (frame_fill < SAMPLES) return;
        frame_fill = 0;
        if (typed_q.size() > 0) begin
            median_q.push_back(typed_q.pop_front());
            return;
        end
        done_mask = '0;
        have_held = 1'b0;
        for (int i = 0; i < SAMPLES; i++) begin
            if (!done_mask[frame_ch[i]]) begin
                done_mask[frame_ch[i]] = 1'b1;
                if (have_held) median_q.push_back(held);
                held.out_channel = frame_ch[i];
                held.median      = rank_middle(frame_ch[i]);
                held.last_result = 1'b0;
                have_held        = 1'b1;
            end
        end
        // the final median of the frame carries the last mark
        held.last_result = 1'b1;
        median_q.push_back(held);
    endtask

    // mostly no gap or a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(input logic [CH_FIELD_W-1:0] ch, input logic [VAL_FIELD_W-1:0] val);
        int gap;
        gap = quiet_in ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in       = '{channel: ch, value: val};
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // prediction and checking in one process, so their order within an edge is fixed
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) absorb_sample(i_in);
            if (o_out_valid && i_out_ready) begin
                if (median_q.size() == 0) begin
                    report_mismatch("word with nothing expected, channel",
                                    o_out.out_channel, -1);
                end else begin
                    want = median_q.pop_front();
                    if (o_out.out_channel !== want.out_channel)
                        report_mismatch("out_channel", o_out.out_channel, want.out_channel);
                    if (o_out.median !== want.median)
                        report_mismatch("median", o_out.median, want.median);
                    if (o_out.last_result !== want.last_result)
                        report_mismatch("last_result", o_out.last_result, want.last_result);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** per_channel_median_filter_top: FAILED **");
            $finish;
        end
    end

    // receiver: ready runs broken by stalls of random length
    initial begin : out_ready_drive
        int run;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
            i_out_ready = 1'b1;
            repeat (run) @(negedge i_clk);
            run = pick_gap();
            if (run > 0) begin
                i_out_ready = 1'b0;
                repeat (run) @(negedge i_clk);
            end
        end
    end

    initial begin : main
        logic [CH_FIELD_W-1:0]  ch;
        logic [CH_FIELD_W-1:0]  base;
        logic [VAL_FIELD_W-1:0] val;
        logic [VAL_FIELD_W-1:0] lo;
        int                     style;
        int                     vmode;
        int                     span;

        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in       = '0;

        // one channel at the bottom, then one at the top, results typed in
        plan[0] = '{5'd0,  12'd0,    64, 0,  0, 1'b1, '{5'd0,  12'd0,    1'b1}};
        plan[1] = '{5'd31, 12'd4095, 64, 0,  0, 1'b1, '{5'd31, 12'd4095, 1'b1}};
        // every channel twice: 32 results, even counts take the upper median
        plan[2] = '{5'd0,  12'd100,  32, 1,  3, 1'b0, '0};
        plan[3] = '{5'd0,  12'd4095, 32, 1, -1, 1'b0, '0};
        // long descending run on one channel, a lone sample on another,
        // then a late outlier on the first; order of first appearance 7 then 2
        plan[4] = '{5'd7,  12'd63,   62, 0, -1, 1'b0, '0};
        plan[5] = '{5'd2,  12'd9,     1, 0,  0, 1'b0, '0};
        plan[6] = '{5'd7,  12'd4095,  1, 0,  0, 1'b0, '0};

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (plan[r]) begin
            if (plan[r].pinned) typed_q.push_back(plan[r].exp_word);
            for (int j = 0; j < plan[r].reps; j++)
                send_word(CH_FIELD_W'(int'(plan[r].ch) + j * plan[r].ch_step),
                          VAL_FIELD_W'(int'(plan[r].val) + j * plan[r].val_step));
        end

        // random frames: channel mix and value spread picked per frame
        for (int f = 0; f < RANDOM_FRAMES; f++) begin
            style    = $urandom_range(0, 3);
            vmode    = $urandom_range(0, 2);
            span     = $urandom_range(1, 4);
            base     = CH_FIELD_W'($urandom_range(0, 31));
            lo       = VAL_FIELD_W'($urandom_range(0, 4095 - 7));
            quiet_in = ($urandom_range(0, 3) == 0);
            for (int j = 0; j < SAMPLES; j++) begin
                case (style)
                    0: ch = CH_FIELD_W'($urandom_range(0, 31));
                    1: ch = CH_FIELD_W'(base + $urandom_range(0, span - 1));
                    2: ch = base;
                    // all channels, in a shuffled first-appearance order
                    default: ch = (j < 32) ? (CH_FIELD_W'(j) ^ base)
                                           : CH_FIELD_W'($urandom_range(0, 31));
                endcase
                case (vmode)
                    0: val = VAL_FIELD_W'($urandom_range(0, 4095));
                    1: begin
                        case ($urandom_range(0, 2))
                            0: val = '0;
                            1: val = '1;
                            default: val = VAL_FIELD_W'($urandom_range(0, 4095));
                        endcase
                    end
                    // narrow band: many duplicates
                    default: val = VAL_FIELD_W'(lo + $urandom_range(0, 7));
                endcase
                send_word(ch, val);
            end
        end
        i_in_valid = 1'b0;
        quiet_in   = 1'b0;

        while (median_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("** per_channel_median_filter_top: PASSED **");
        end else begin
            $display("** per_channel_median_filter_top: FAILED **");
        end
        $finish;
    end

endmodule
